@@ rtl/triangle_box_overlap_test_macros.svh @@
// assertion helpers for the triangle box overlap block
`ifndef TRIANGLE_BOX_OVERLAP_TEST_MACROS_SVH
`define TRIANGLE_BOX_OVERLAP_TEST_MACROS_SVH

// clocked check, off while reset is asserted
`define TBO_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("tbo assertion failed");

// condition that must never be seen
`define TBO_NEVER(lbl, expr) `TBO_ASSERT(lbl, !(expr))

`endif

@@ rtl/tbo_pkg.sv @@
package tbo_pkg;

	// field and intermediate widths
	localparam int CW  = 24;          // coordinate
	localparam int HW  = 23;          // half size
	localparam int VW  = CW + 1;      // vertex offset
	localparam int EW  = CW + 2;      // edge
	localparam int PMW = EW + VW;     // edge times offset
	localparam int PW  = PMW + 1;     // edge axis projection
	localparam int RMW = EW + HW;     // |edge| times half size
	localparam int RW  = RMW + 1;     // edge axis radius
	localparam int NMW = 2 * EW;      // edge times edge
	localparam int NW  = NMW + 1;     // normal component
	localparam int NLW = 27;          // low split of normal
	localparam int NHW = NW - NLW;    // high split of normal
	localparam int DW  = 80;          // plane distance
	localparam int PRW = 78;          // plane radius
	localparam int NFIELDS = 12;
	localparam int IN_BYTES_W = NFIELDS * CW;

	// register indexes of the configuration port
	localparam logic [1:0] REG_HALF_X = 2'd0;
	localparam logic [1:0] REG_HALF_Y = 2'd1;
	localparam logic [1:0] REG_HALF_Z = 2'd2;

	localparam logic [HW-1:0] HALF_RESET = HW'(256);

	typedef logic signed [VW-1:0] off_t;
	typedef logic signed [EW-1:0] edge_t;
	typedef logic [HW-1:0] half_t;

endpackage

@@ rtl/tbo_plane.sv @@
// triangle plane against box, five register stages after the edge stage
module tbo_plane (
	input  logic            clk,
	input  logic            en,
	input  tbo_pkg::edge_t  e0 [3],
	input  tbo_pkg::edge_t  e1 [3],
	input  tbo_pkg::off_t   v0 [3],
	input  tbo_pkg::half_t  h  [3],
	output logic            sep
);

	logic signed [tbo_pkg::NMW-1:0] na_s3 [3];
	logic signed [tbo_pkg::NMW-1:0] nb_s3 [3];
	tbo_pkg::off_t                  v0_s3 [3];
	logic signed [tbo_pkg::NW-1:0]  n_s4  [3];
	tbo_pkg::off_t                  v0_s4 [3];
	logic signed [tbo_pkg::NLW+tbo_pkg::VW:0]   dlo_s5 [3];
	logic signed [tbo_pkg::NHW+tbo_pkg::VW-1:0] dhi_s5 [3];
	logic [tbo_pkg::NLW+tbo_pkg::HW-1:0]        rlo_s5 [3];
	logic [tbo_pkg::NHW+tbo_pkg::HW-1:0]        rhi_s5 [3];
	logic signed [tbo_pkg::DW-1:0]  dt_s6 [3];
	logic [tbo_pkg::PRW-1:0]        rt_s6 [3];
	logic signed [tbo_pkg::DW-1:0]  d_s7;
	logic [tbo_pkg::PRW-1:0]        r_s7;

	logic [tbo_pkg::NW-1:0]         n_abs [3];
	logic signed [tbo_pkg::DW:0]    d_ext;
	logic signed [tbo_pkg::DW:0]    r_ext;

	// magnitude of each normal component
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			n_abs[k] = n_s4[k][tbo_pkg::NW-1] ? tbo_pkg::NW'(-n_s4[k])
			                                  : tbo_pkg::NW'(n_s4[k]);
		end
	end

	// stage 3 to 7: normal products, normal, split products, terms, sums
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				na_s3[k] <= e0[(k+1)%3] * e1[(k+2)%3];
				nb_s3[k] <= e0[(k+2)%3] * e1[(k+1)%3];
				v0_s3[k] <= v0[k];
				n_s4[k]  <= tbo_pkg::NW'(na_s3[k]) - tbo_pkg::NW'(nb_s3[k]);
				v0_s4[k] <= v0_s3[k];
				dlo_s5[k] <= $signed({1'b0, n_s4[k][tbo_pkg::NLW-1:0]}) * v0_s4[k];
				dhi_s5[k] <= $signed(n_s4[k][tbo_pkg::NW-1:tbo_pkg::NLW]) * v0_s4[k];
				rlo_s5[k] <= n_abs[k][tbo_pkg::NLW-1:0] * h[k];
				rhi_s5[k] <= n_abs[k][tbo_pkg::NW-1:tbo_pkg::NLW] * h[k];
				dt_s6[k] <= (tbo_pkg::DW'(dhi_s5[k]) <<< tbo_pkg::NLW)
				          + tbo_pkg::DW'(dlo_s5[k]);
				rt_s6[k] <= (tbo_pkg::PRW'(rhi_s5[k]) << tbo_pkg::NLW)
				          + tbo_pkg::PRW'(rlo_s5[k]);
			end
			d_s7 <= dt_s6[0] + dt_s6[1] + dt_s6[2];
			r_s7 <= rt_s6[0] + rt_s6[1] + rt_s6[2];
		end
	end

	// box centre lies outside the slab of the plane
	assign d_ext = (tbo_pkg::DW+1)'(d_s7);
	assign r_ext = $signed({3'b000, r_s7});
	assign sep   = (d_ext > r_ext) || (d_ext < -r_ext);

endmodule

@@ rtl/triangle_box_overlap_test.sv @@
// Triangle against axis-aligned box overlap, separating axis test. One request
// (box centre and three vertices, 24-bit signed coordinates with 8 fraction bits)
// can be taken every clock unless the pipeline holds; the answer passes through
// the eight register stages (offsets, edges, products, projections, split
// plane products, plane terms, plane sums, result register), the first of which
// is loaded at the accepting edge. The whole pipeline advances together and holds
// while a finished result waits on m_axis_tready. Half sizes are written through
// the cfg port (index 0, 1, 2 for x, y, z, reset 1.0) by the user only while no
// request is in flight; the block does not enforce it. Touching counts as overlap.
module triangle_box_overlap_test (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// center_x, center_y, center_z, vert_a_x..z, vert_b_x..z, vert_c_x..z
	input  logic [tbo_pkg::IN_BYTES_W-1:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// overlaps, then seven zero bits
	output logic [7:0]  m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [tbo_pkg::HW-1:0] cfg_data
);

	tbo_pkg::half_t hx_q, hy_q, hz_q;
	tbo_pkg::half_t h [3];
	logic [8:1]     vld_q;
	logic           en;

	tbo_pkg::off_t  v_s1 [3][3];
	tbo_pkg::off_t  v_s2 [3][3];
	tbo_pkg::edge_t e_s2 [3][3];
	logic           axsep_s2, axsep_s3, axsep_s4;
	logic signed [tbo_pkg::PMW-1:0] pa_s3 [3][3][2];
	logic signed [tbo_pkg::PMW-1:0] pb_s3 [3][3][2];
	logic [tbo_pkg::RMW-1:0]        ra_s3 [3][3];
	logic [tbo_pkg::RMW-1:0]        rb_s3 [3][3];
	logic signed [tbo_pkg::PW-1:0]  p_s4  [3][3][2];
	logic [tbo_pkg::RW-1:0]         rad_s4 [3][3];
	logic           sep_s5, sep_s6, sep_s7;
	logic           ovl_s8;
	logic           plane_sep;

	logic [tbo_pkg::EW-1:0]         e_abs [3][3];
	logic                           axsep;
	logic                           edgesep;

	assign en            = !vld_q[8] || m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = vld_q[8];
	assign m_axis_tdata  = {7'b0000000, ovl_s8};
	assign h[0] = hx_q;
	assign h[1] = hy_q;
	assign h[2] = hz_q;

	// half size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hx_q <= tbo_pkg::HALF_RESET;
			hy_q <= tbo_pkg::HALF_RESET;
			hz_q <= tbo_pkg::HALF_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tbo_pkg::REG_HALF_X: hx_q <= cfg_data;
				tbo_pkg::REG_HALF_Y: hy_q <= cfg_data;
				tbo_pkg::REG_HALF_Z: hz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[7:1], s_axis_tvalid};
		end
	end

	// coordinate axis min/max test on the offsets
	always_comb begin
		axsep = 1'b0;
		for (int k = 0; k < 3; k++) begin
			if (($signed(v_s1[0][k]) > $signed({2'b00, h[k]}) &&
			     $signed(v_s1[1][k]) > $signed({2'b00, h[k]}) &&
			     $signed(v_s1[2][k]) > $signed({2'b00, h[k]})) ||
			    ($signed(v_s1[0][k]) < -$signed({2'b00, h[k]}) &&
			     $signed(v_s1[1][k]) < -$signed({2'b00, h[k]}) &&
			     $signed(v_s1[2][k]) < -$signed({2'b00, h[k]}))) begin
				axsep = 1'b1;
			end
		end
	end

	// edge magnitudes
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				e_abs[i][k] = e_s2[i][k][tbo_pkg::EW-1] ? tbo_pkg::EW'(-e_s2[i][k])
				                                        : tbo_pkg::EW'(e_s2[i][k]);
			end
		end
	end

	// edge axis test, both distinct projections against the radius
	always_comb begin
		edgesep = 1'b0;
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				if (($signed(p_s4[i][k][0]) > $signed({2'b00, rad_s4[i][k]}) &&
				     $signed(p_s4[i][k][1]) > $signed({2'b00, rad_s4[i][k]})) ||
				    ($signed(p_s4[i][k][0]) < -$signed({2'b00, rad_s4[i][k]}) &&
				     $signed(p_s4[i][k][1]) < -$signed({2'b00, rad_s4[i][k]}))) begin
					edgesep = 1'b1;
				end
			end
		end
	end

	// main datapath stages
	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: move vertices so the box centre is the origin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					v_s1[i][k] <= tbo_pkg::VW'($signed(s_axis_tdata[(3+3*i+k)*tbo_pkg::CW +:
					                                                 tbo_pkg::CW]))
					            - tbo_pkg::VW'($signed(s_axis_tdata[k*tbo_pkg::CW +:
					                                                 tbo_pkg::CW]));
				end
			end
			// stage 2: edges
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					e_s2[i][k] <= tbo_pkg::EW'(v_s1[(i+1)%3][k]) - tbo_pkg::EW'(v_s1[i][k]);
					v_s2[i][k] <= v_s1[i][k];
				end
			end
			axsep_s2 <= axsep;
			// stage 3: projection and radius products
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					for (int q = 0; q < 2; q++) begin
						pa_s3[i][k][q] <= e_s2[i][(k+2)%3] * v_s2[(i+2*q)%3][(k+1)%3];
						pb_s3[i][k][q] <= e_s2[i][(k+1)%3] * v_s2[(i+2*q)%3][(k+2)%3];
					end
					ra_s3[i][k] <= e_abs[i][(k+2)%3] * h[(k+1)%3];
					rb_s3[i][k] <= e_abs[i][(k+1)%3] * h[(k+2)%3];
				end
			end
			axsep_s3 <= axsep_s2;
			// stage 4: projections and radii
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					for (int q = 0; q < 2; q++) begin
						p_s4[i][k][q] <= tbo_pkg::PW'(pa_s3[i][k][q])
						               - tbo_pkg::PW'(pb_s3[i][k][q]);
					end
					rad_s4[i][k] <= tbo_pkg::RW'(ra_s3[i][k]) + tbo_pkg::RW'(rb_s3[i][k]);
				end
			end
			axsep_s4 <= axsep_s3;
			// stage 5 to 8: collect separation flags
			sep_s5 <= axsep_s4 || edgesep;
			sep_s6 <= sep_s5;
			sep_s7 <= sep_s6;
			ovl_s8 <= !(sep_s7 || plane_sep);
		end
	end

	// triangle plane test
	tbo_plane u_plane (
		.clk (clk),
		.en  (en),
		.e0  (e_s2[0]),
		.e1  (e_s2[1]),
		.v0  (v_s2[0]),
		.h   (h),
		.sep (plane_sep)
	);

endmodule

@@ rtl/tbo_checker.sv @@
`include "triangle_box_overlap_test_macros.svh"

// port-level checks for the overlap block
module tbo_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [7:0]   m_axis_tdata,
	input logic         cfg_ready
);

	// a stalled result holds
	`TBO_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

	// with no result pending the pipeline takes requests
	`TBO_NEVER(a_ready_free, !m_axis_tvalid && !s_axis_tready)

	// padding of the result stays zero
	`TBO_NEVER(a_pad_zero, m_axis_tvalid && m_axis_tdata[7:1] != 7'd0)

	// register writes are always taken
	`TBO_NEVER(a_cfg_free, !cfg_ready)

endmodule

bind triangle_box_overlap_test tbo_checker u_tbo_checker (.*);

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;

	typedef logic signed [127:0] wide_t;

	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int PHASE_ITEMS = 240;
	localparam int TAIL_CYCLES = 12;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam logic [tbo_pkg::CW-1:0] C_MAX = 24'h7fffff;
	localparam logic [tbo_pkg::CW-1:0] C_MIN = 24'h800000;
	localparam logic [tbo_pkg::CW-1:0] ONE = 24'd256;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [287:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [22:0] cfg_data;

	logic [287:0] triangle_q[$];
	bit overlap_q[$];
	logic [2:0][tbo_pkg::HW-1:0] half_now;
	int n_errors = 0;
	int n_results = 0;
	int idle_cycles = 0;

	triangle_box_overlap_test uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic wide_t mag(wide_t x);
		return (x < 0) ? -x : x;
	endfunction

	// separating axis test on centred vertices, exact wide arithmetic
	function automatic bit box_hit(logic [287:0] d, logic [2:0][tbo_pkg::HW-1:0] hs);
		wide_t v[3][3];
		wide_t e[3][3];
		wide_t h[3];
		wide_t nrm[3];
		wide_t p, mn, mx, rad, pdist, prad;
		bit ok;
		int j, l;
		ok = 1'b1;
		for (int k = 0; k < 3; k++) h[k] = hs[k];
		for (int i = 0; i < 3; i++)
			for (int k = 0; k < 3; k++)
				v[i][k] = $signed(d[(3 + 3 * i + k) * tbo_pkg::CW +: tbo_pkg::CW])
					- $signed(d[k * tbo_pkg::CW +: tbo_pkg::CW]);
		for (int i = 0; i < 3; i++)
			for (int k = 0; k < 3; k++)
				e[i][k] = v[(i + 1) % 3][k] - v[i][k];
		// edge cross axis projections
		for (int i = 0; i < 3; i++)
			for (int k = 0; k < 3; k++) begin
				j = (k + 1) % 3;
				l = (k + 2) % 3;
				for (int q = 0; q < 3; q++) begin
					p = e[i][l] * v[q][j] - e[i][j] * v[q][l];
					if (q == 0 || p < mn) mn = p;
					if (q == 0 || p > mx) mx = p;
				end
				rad = mag(e[i][l]) * h[j] + mag(e[i][j]) * h[l];
				if (rad < mn || mx < -rad) ok = 1'b0;
			end
		// coordinate axes
		for (int k = 0; k < 3; k++) begin
			mn = v[0][k];
			mx = v[0][k];
			for (int q = 1; q < 3; q++) begin
				if (v[q][k] < mn) mn = v[q][k];
				if (v[q][k] > mx) mx = v[q][k];
			end
			if (h[k] < mn || mx < -h[k]) ok = 1'b0;
		end
		// triangle plane
		for (int k = 0; k < 3; k++) begin
			j = (k + 1) % 3;
			l = (k + 2) % 3;
			nrm[k] = e[0][j] * e[1][l] - e[0][l] * e[1][j];
		end
		pdist = 0;
		prad = 0;
		for (int k = 0; k < 3; k++) begin
			pdist = pdist + nrm[k] * v[0][k];
			prad = prad + mag(nrm[k]) * h[k];
		end
		if (pdist < -prad || prad < pdist) ok = 1'b0;
		return ok;
	endfunction

	function automatic logic [287:0] pack_request(logic [tbo_pkg::CW-1:0] c[12]);
		logic [287:0] d;
		for (int f = 0; f < 12; f++) d[f * tbo_pkg::CW +: tbo_pkg::CW] = c[f];
		return d;
	endfunction

	// random triangle: vertices spread around a centre at one of several scales
	function automatic logic [287:0] random_request();
		logic [tbo_pkg::CW-1:0] c[12];
		int span;
		logic [tbo_pkg::CW-1:0] base;
		case ($urandom_range(0, 9))
			0: span = 0;
			1, 2: span = 64;
			3, 4, 5: span = 512;
			6, 7: span = 4096;
			8: span = 1 << 20;
			default: span = -1;
		endcase
		base = ($urandom_range(0, 3) == 0) ? tbo_pkg::CW'($urandom())
			: tbo_pkg::CW'($urandom_range(0, 2048) - 1024);
		for (int f = 0; f < 12; f++) begin
			if (span < 0) c[f] = tbo_pkg::CW'($urandom());
			else if (f < 3) c[f] = tbo_pkg::CW'(base + $urandom_range(0, 2 * span) - span);
			else c[f] = tbo_pkg::CW'(c[f % 3] + $urandom_range(0, 4 * span + 2)
				- (2 * span + 1));
		end
		return pack_request(c);
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [tbo_pkg::HW-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		cfg_valid <= 1'b0;
		if (idx != REG_SPARE) half_now[idx] = val;
	endtask

	task automatic set_box(logic [tbo_pkg::HW-1:0] hx, logic [tbo_pkg::HW-1:0] hy,
			logic [tbo_pkg::HW-1:0] hz);
		write_reg(tbo_pkg::REG_HALF_X, hx);
		write_reg(tbo_pkg::REG_HALF_Y, hy);
		write_reg(tbo_pkg::REG_HALF_Z, hz);
	endtask

	task automatic drain();
		do @(posedge clk);
		while (triangle_q.size() != 0 || s_axis_tvalid || overlap_q.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic add_directed(logic [tbo_pkg::CW-1:0] cx, logic [tbo_pkg::CW-1:0] cy,
			logic [tbo_pkg::CW-1:0] cz,
			logic [tbo_pkg::CW-1:0] ax, logic [tbo_pkg::CW-1:0] ay, logic [tbo_pkg::CW-1:0] az,
			logic [tbo_pkg::CW-1:0] bx, logic [tbo_pkg::CW-1:0] by, logic [tbo_pkg::CW-1:0] bz,
			logic [tbo_pkg::CW-1:0] qx, logic [tbo_pkg::CW-1:0] qy, logic [tbo_pkg::CW-1:0] qz);
		logic [tbo_pkg::CW-1:0] c[12];
		c = '{cx, cy, cz, ax, ay, az, bx, by, bz, qx, qy, qz};
		triangle_q.push_back(pack_request(c));
	endtask

	// stimulus and phases
	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = tbo_pkg::REG_HALF_X;
		cfg_data = '0;
		half_now = {tbo_pkg::HALF_RESET, tbo_pkg::HALF_RESET, tbo_pkg::HALF_RESET};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed cases at reset half sizes
		add_directed(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_directed(0, 0, 0, -100, -100, 0, 100, -100, 0, 0, 100, 0);
		add_directed(0, 0, 0, 1000, 0, 0, 1000, 500, 0, 1000, 0, 500);
		add_directed(0, 0, 0, ONE, -500, -500, ONE, 500, -500, ONE, 0, 500);
		add_directed(0, 0, 0, ONE + 1, -500, -500, ONE + 1, 500, -500, ONE + 1, 0, 500);
		add_directed(0, 0, 0, 600, 0, 0, 0, 600, 0, 0, 0, 600);
		add_directed(0, 0, 0, 768, 0, 0, 0, 768, 0, 0, 0, 768);
		add_directed(0, 0, 0, 769, 0, 0, 0, 769, 0, 0, 0, 769);
		add_directed(0, 0, 0, 300, 300, 0, 300, 300, 0, 300, 300, 0);
		add_directed(0, 0, 0, -300, 0, 300, 0, 300, 300, 300, 0, 300);
		add_directed(0, 0, 0, 300, -500, 0, 500, -300, 0, 500, -300, 100);
		add_directed(0, 0, 0, 50, 50, 50, 50, 50, 50, 50, 50, 50);
		add_directed(0, 0, 0, -1000, -1000, 10, 1000, 1000, 10, 2000, 2000, 10);
		add_directed(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX,
			C_MIN, C_MAX, C_MIN);
		add_directed(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, C_MAX, C_MIN,
			C_MAX, C_MIN, C_MAX);
		add_directed(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
			C_MAX, C_MAX, C_MAX);
		add_directed(C_MIN, 0, C_MAX, C_MIN, 0, C_MAX, C_MIN, 10, C_MAX, C_MIN, 0, C_MAX);
		for (int n = 0; n < PHASE_ITEMS; n++) triangle_q.push_back(random_request());
		drain();

		// flat box
		set_box(0, 0, 0);
		add_directed(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_directed(0, 0, 0, -10, -10, 0, 10, -10, 0, 0, 10, 0);
		add_directed(0, 0, 0, 1, 1, 1, 2, 1, 1, 1, 2, 1);
		for (int n = 0; n < PHASE_ITEMS; n++) triangle_q.push_back(random_request());
		drain();

		// largest box
		set_box({tbo_pkg::HW{1'b1}}, {tbo_pkg::HW{1'b1}}, {tbo_pkg::HW{1'b1}});
		for (int n = 0; n < PHASE_ITEMS; n++) triangle_q.push_back(random_request());
		drain();

		// lopsided box, spare index must not disturb it
		set_box(100, {tbo_pkg::HW{1'b1}}, 3);
		write_reg(REG_SPARE, 23'd5);
		for (int n = 0; n < PHASE_ITEMS; n++) triangle_q.push_back(random_request());
		drain();

		// random boxes
		for (int ph = 0; ph < 2; ph++) begin
			set_box(tbo_pkg::HW'($urandom_range(0, 4096)), tbo_pkg::HW'($urandom_range(0, 4096)),
				tbo_pkg::HW'($urandom()));
			for (int n = 0; n < PHASE_ITEMS / 2; n++) triangle_q.push_back(random_request());
			drain();
		end

		if (n_errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// request driver with random gaps and bursts
	int gap = 0;
	int burst = 0;
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			overlap_q.push_back(box_hit(s_axis_tdata, half_now));
		end
		if (!(s_axis_tvalid && !s_axis_tready)) begin
			if (gap > 0) begin
				gap <= gap - 1;
				s_axis_tvalid <= 1'b0;
			end else if (triangle_q.size() != 0) begin
				s_axis_tdata <= triangle_q.pop_front();
				s_axis_tvalid <= 1'b1;
				if (burst > 0) begin
					burst <= burst - 1;
					gap <= 0;
				end else if ($urandom_range(0, 49) == 0) begin
					burst <= $urandom_range(20, 80);
					gap <= 0;
				end else begin
					case ($urandom_range(0, 19))
						0: gap <= $urandom_range(10, 40);
						1, 2, 3, 4, 5, 6: gap <= $urandom_range(1, 3);
						default: gap <= 0;
					endcase
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver readiness, with one long hold-off to fill the pipeline
	int hold = 0;
	bit long_hold_done = 1'b0;
	always @(posedge clk) begin
		if (hold > 0) begin
			hold <= hold - 1;
			m_axis_tready <= 1'b0;
		end else if (!long_hold_done && n_results >= 300) begin
			long_hold_done <= 1'b1;
			hold <= 300;
			m_axis_tready <= 1'b0;
		end else begin
			case ($urandom_range(0, 29))
				0: hold <= $urandom_range(10, 40);
				1, 2, 3, 4, 5, 6: hold <= $urandom_range(0, 3);
				default: hold <= 0;
			endcase
			m_axis_tready <= 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			n_results <= n_results + 1;
			if (overlap_q.size() == 0) begin
				$error("unexpected result, overlaps actual %0b", m_axis_tdata[0]);
				n_errors++;
			end else if (m_axis_tdata[0] !== overlap_q[0]) begin
				$error("overlaps mismatch: expected %0b actual %0b", overlap_q[0],
					m_axis_tdata[0]);
				n_errors++;
				void'(overlap_q.pop_front());
			end else begin
				void'(overlap_q.pop_front());
			end
		end
	end

	// watchdog on stalled traffic
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

endmodule
